/* sv/swmm_pkg.sv */
package swmm_pkg;

  // Configuration register map
  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH     = 1'b0,
    REG_WINDOW_RECIPROCAL = 1'b1
  } cfg_index_t;

  // Register widths
  localparam int WLEN_W    = 11;
  localparam int RECIP_W   = 17;
  localparam int CFG_DATA_W = 17;

  // Reciprocal is Q1.16
  localparam int FRAC_W = 16;

  // Reset values
  localparam logic [WLEN_W-1:0]  WLEN_RESET  = 11'd1024;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 17'd64;

endpackage

/* sv/sliding_window_mean_magnitude_unit.sv */
// Sliding-window mean magnitude. Each input item is one signed sample; each
// accepted item gives exactly one result item, the mean magnitude of the last
// window_length samples, (sum * window_reciprocal + 2^15) >> 16 saturated at
// 2^(SAMPLE_BITS-1). The divisor is always the full window, so results ramp up
// while the window fills. One item is taken per clock unless the output stalls;
// a result moves through stages 1, 2 and 3 and the output register. The rate is
// set by the ring memory, which does one read-first access (old magnitude out,
// new magnitude in) per item on a single port. Writing window_length restarts
// the window; write the registers only while no item is in flight.
module sliding_window_mean_magnitude_unit #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  swmm_pkg::cfg_index_t                   cfg_index,
  input  logic [swmm_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input items
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // [0]: sample
  // result items
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata   // [0]: window_power
);
  import swmm_pkg::*;

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int SUM_X  = (SUM_W > FRAC_W + 1) ? SUM_W : FRAC_W + 1;
  localparam int HI_W   = SUM_X - FRAC_W;
  localparam int HIP_W  = HI_W + RECIP_W;
  localparam int LOP_W  = FRAC_W + RECIP_W;
  localparam int RES_W  = HIP_W + 1;
  localparam logic [RES_W-1:0] SAT_VAL = RES_W'(1) << (SAMPLE_BITS - 1);

  // Configuration
  logic [WLEN_W-1:0]  window_length;
  logic [RECIP_W-1:0] window_reciprocal;
  logic [LEN_W-1:0]   eff_len;

  // Window bookkeeping
  logic [PTR_W-1:0]   write_position;
  logic [LEN_W-1:0]   fill_count;
  logic [PTR_W-1:0]   pos;
  logic [LEN_W-1:0]   pos_inc;
  logic               full;

  // Ring memory
  logic [SAMPLE_BITS-1:0] magnitude_ring [MAX_WINDOW];

  // Stage 1: new magnitude, old magnitude read from the ring
  logic                   v1;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] mag1;
  logic [SAMPLE_BITS-1:0] old1;
  logic                   full1;

  // Stage 2: running sum
  logic                   v2;
  logic [SUM_W-1:0]       running_sum;
  logic [SUM_W-1:0]       running_sum_next;
  logic [SUM_X-1:0]       sum_ext;

  // Stage 3: partial products
  logic                   v3;
  logic [HIP_W-1:0]       hi_prod;
  logic [LOP_W-1:0]       lo_prod;

  // Output stage
  logic [RES_W-1:0]       scaled;
  logic [SAMPLE_BITS-1:0] window_power;

  logic ready_out, ready3, ready2, ready1;
  logic accept;

  // Per-stage flow control
  assign ready_out     = !m_axis_tvalid || m_axis_tready;
  assign ready3        = !v3 || ready_out;
  assign ready2        = !v2 || ready3;
  assign ready1        = !v1 || ready2;
  assign s_axis_tready = ready1;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Clamp window length into 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_length);
    end
  end

  // Slot for this item and the one after
  always_comb begin
    pos     = (LEN_W'(write_position) >= eff_len) ? '0 : write_position;
    pos_inc = LEN_W'(pos) + LEN_W'(1);
    full    = fill_count >= eff_len;
  end

  // Magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1)
  always_comb begin
    if (s_axis_tdata[SAMPLE_BITS-1]) begin
      mag = ~s_axis_tdata[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1);
    end else begin
      mag = s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  // Configuration registers and window pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WLEN_RESET;
      window_reciprocal <= RECIP_RESET;
      write_position    <= '0;
      fill_count        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: begin
          window_length  <= cfg_data[WLEN_W-1:0];
          write_position <= '0;
          fill_count     <= '0;
        end
        REG_WINDOW_RECIPROCAL: begin
          window_reciprocal <= cfg_data[RECIP_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      write_position <= (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
      if (!full) begin
        fill_count <= fill_count + LEN_W'(1);
      end
    end
  end

  // Ring: read-first single port, old entry lands in old1
  always_ff @(posedge clk) begin
    if (accept) begin
      old1                <= magnitude_ring[pos];
      magnitude_ring[pos] <= mag;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mag1  <= mag;
      full1 <= full;
    end
  end

  // Sum update: add newest, drop the overwritten one once full
  always_comb begin
    running_sum_next = running_sum + SUM_W'(mag1);
    if (full1) begin
      running_sum_next = running_sum_next - SUM_W'(old1);
    end
  end

  assign sum_ext = SUM_X'(running_sum);

  // Valid bits and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      running_sum   <= '0;
    end else begin
      if (ready1) begin
        v1 <= s_axis_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready_out) begin
        m_axis_tvalid <= v3;
      end
      if (cfg_we && cfg_index == REG_WINDOW_LENGTH) begin
        running_sum <= '0;
      end else if (v1 && ready2) begin
        running_sum <= running_sum_next;
      end
    end
  end

  // Scaling split into a high part and the low FRAC_W bits of the sum
  always_ff @(posedge clk) begin
    if (v2 && ready3) begin
      hi_prod <= HIP_W'(sum_ext[SUM_X-1:FRAC_W]) * HIP_W'(window_reciprocal);
      lo_prod <= LOP_W'(sum_ext[FRAC_W-1:0]) * LOP_W'(window_reciprocal);
    end
  end

  // Round half up and saturate
  always_comb begin
    scaled = RES_W'(hi_prod) + RES_W'(lo_prod[LOP_W-1:FRAC_W])
           + RES_W'(lo_prod[FRAC_W-1]);
    if (scaled > SAT_VAL) begin
      window_power = SAT_VAL[SAMPLE_BITS-1:0];
    end else begin
      window_power = scaled[SAMPLE_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (v3 && ready_out) begin
      m_axis_tdata <= DATA_W'(window_power);
    end
  end

  // Fill count never runs past the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= eff_len)
    else $error("fill count exceeds window length");

  // Write pointer stays inside the window
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(write_position) < eff_len)
    else $error("write position outside window");

  // An accepted item always occupies stage 1 next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted item lost at stage 1");

  // Results never exceed the saturation level
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (RES_W'(m_axis_tdata[SAMPLE_BITS-1:0]) <= SAT_VAL))
    else $error("result above saturation level");

endmodule
